@@ rtl/nau_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nau_pkg
// Shared types, constants and elaboration-time tables for the activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int FUNC_W = 3;
  localparam int X_W    = 16;
  localparam int Y_W    = 24;
  localparam int GAIN_W = 16;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_GAIN_IDX = 1'b0;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd256;

  localparam int QDEPTH_DEF = 4;
  localparam int EXP_STEPS  = 24;   // e^-1 multiply stages
  localparam int EXP_ZERO_K = 22;   // from this many steps on the value is gone
  localparam int LN_TERMS   = 16;
  localparam int DIV_BITS   = 31;   // quotient bits, Q30 results up to 1.0

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam longint unsigned Q30_ONE_L = 64'd1 << 30;

  // func selector codes
  localparam logic [FUNC_W-1:0] FUNC_SIG    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIGD   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TANH   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TANHD  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SOFTP  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SOFTPD = 3'd5;

  typedef enum logic [2:0] {
    OP_SIG   = 3'd0,
    OP_SIGD  = 3'd1,
    OP_TANH  = 3'd2,
    OP_TANHD = 3'd3,
    OP_SOFTP = 3'd4,
    OP_ZERO  = 3'd5
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [X_W-1:0]   z;
  } side_t;

  typedef logic [30:0] exp_tab_t [256];
  typedef logic [30:0] recip_t [LN_TERMS];

  // floor(2^30 / (2i+1)) for the odd-term divisions of the log series
  localparam recip_t RECIP = '{
    31'(Q30_ONE_L / 1),  31'(Q30_ONE_L / 3),  31'(Q30_ONE_L / 5),  31'(Q30_ONE_L / 7),
    31'(Q30_ONE_L / 9),  31'(Q30_ONE_L / 11), 31'(Q30_ONE_L / 13), 31'(Q30_ONE_L / 15),
    31'(Q30_ONE_L / 17), 31'(Q30_ONE_L / 19), 31'(Q30_ONE_L / 21), 31'(Q30_ONE_L / 23),
    31'(Q30_ONE_L / 25), 31'(Q30_ONE_L / 27), 31'(Q30_ONE_L / 29), 31'(Q30_ONE_L / 31)
  };

  // 21-term alternating series for e^-t, t in Q30, 0 <= t <= 1
  function automatic logic [30:0] exp_series(logic [30:0] t);
    logic [63:0] term;
    longint      sum;
    term = 64'(Q30_ONE);
    sum  = longint'(Q30_ONE);
    for (int j = 1; j <= 20; j++) begin
      term = ((term * 64'(t)) >> 30) / 64'(j);
      if (j[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
    return 31'(sum);
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    for (int r = 0; r < 256; r++) begin
      tab[r] = exp_series(31'(r) << 22);
    end
    return tab;
  endfunction

  localparam exp_tab_t    EXP_TAB = build_exp_tab();
  localparam logic [30:0] E1      = exp_series(Q30_ONE);

endpackage
`default_nettype wire

@@ rtl/nau_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nau_front
// Input stage: gain multiply, round and saturate to Q8.8, decode the selector.
// ----------------------------------------------------------------------------
module nau_front import nau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [X_W-1:0]    in_x_value,
  input  logic signed [GAIN_W-1:0] gain,
  output logic                     q_push,
  output side_t                    q_side,
  input  logic                     q_full
);

  logic signed [X_W+GAIN_W-1:0] prod;
  logic signed [X_W+GAIN_W:0]   prod_rnd;
  logic signed [X_W+8:0]        z_wide;
  logic signed [X_W-1:0]        z_sat;
  op_t                          op;
  logic                         accept;
  logic                         f_v_r, f_v_nxt;
  side_t                        f_side_r;

  assign prod     = in_x_value * gain;
  assign prod_rnd = {prod[X_W+GAIN_W-1], prod} + 33'sd128;
  assign z_wide   = prod_rnd[X_W+GAIN_W:8];

  always_comb begin
    if (z_wide > 25'sd32767)       z_sat = 16'sh7fff;
    else if (z_wide < -25'sd32768) z_sat = 16'sh8000;
    else                           z_sat = z_wide[X_W-1:0];
  end

  always_comb begin
    unique case (in_func)
      FUNC_SIG, FUNC_SOFTPD: op = OP_SIG;
      FUNC_SIGD:             op = OP_SIGD;
      FUNC_TANH:             op = OP_TANH;
      FUNC_TANHD:            op = OP_TANHD;
      FUNC_SOFTP:            op = OP_SOFTP;
      default:               op = OP_ZERO;
    endcase
  end

  assign full    = f_v_r && q_full;
  assign accept  = push && !full;
  assign q_push  = f_v_r && !q_full;
  assign q_side  = f_side_r;
  assign f_v_nxt = accept || (f_v_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_side_r.op <= op;
      f_side_r.z  <= z_sat;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nau_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nau_queue
// Small register queue between the front stage and the function pipeline.
// ----------------------------------------------------------------------------
module nau_queue import nau_pkg::*; #(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  side_t push_side,
  output logic  full,
  input  logic  pop,
  output side_t pop_side,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  side_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_side = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_side;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_r == rd_r))
    else $error("queue pointers differ while empty");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule
`default_nettype wire

@@ rtl/nau_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nau_div
// Pipelined restoring divider, one quotient bit per stage, shared by all
// functions (sigmoid, tanh magnitude, log argument).
// ----------------------------------------------------------------------------
module nau_div import nau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [60:0] num,
  input  logic [31:0] den,
  input  side_t       in_side,
  output logic        out_v,
  output logic [30:0] quo,
  output side_t       out_side
);

  localparam int NB = DIV_BITS;

  logic          v_r    [NB+1];
  logic [31:0]   rem_r  [NB+1];
  logic [NB-1:0] lo_r   [NB+1];
  logic [NB-1:0] q_r    [NB+1];
  logic [31:0]   den_r  [NB+1];
  side_t         side_r [NB+1];

  // the upper bits of the dividend are always below the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {2'b00, num[60:NB]};
      lo_r[0]   <= num[NB-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= den;
      side_r[0] <= in_side;
    end
  end

  for (genvar j = 1; j <= NB; j++) begin : g_stage
    logic [32:0] t;
    logic        ge;

    always_comb begin
      t  = {rem_r[j-1], lo_r[j-1][NB-1]};
      ge = (t >= {1'b0, den_r[j-1]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? 32'(t - {1'b0, den_r[j-1]}) : t[31:0];
        lo_r[j]   <= {lo_r[j-1][NB-2:0], 1'b0};
        q_r[j]    <= {q_r[j-1][NB-2:0], ge};
        den_r[j]  <= den_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_v    = v_r[NB];
  assign quo      = q_r[NB];
  assign out_side = side_r[NB];

endmodule
`default_nettype wire

@@ rtl/nau_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nau_back
// Function pipeline: e^-a by table and repeated e^-1 steps, shared divider,
// one multiply, log series and output rounding. All stages move together
// whenever the output register is free or being taken.
// ----------------------------------------------------------------------------
module nau_back import nau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_v,
  input  side_t                 in_side,
  output logic                  take,
  output logic                  out_v,
  input  logic                  out_pop,
  output logic signed [Y_W-1:0] out_y
);

  localparam int S = EXP_STEPS;
  localparam int L = LN_TERMS;

  function automatic logic [19:0] to_q16(logic [32:0] v);
    logic [33:0] t;
    t = {1'b0, v} + 34'd8192;
    return t[33:14];
  endfunction

  logic                  en;
  logic                  out_v_r;
  logic signed [Y_W-1:0] out_y_r, y_nxt;

  assign en   = !out_v_r || out_pop;
  assign take = en && in_v;

  // ---------------- e^-a ----------------
  logic        e_v_r    [S+1];
  logic [30:0] e_val_r  [S+1];
  logic [8:0]  e_k_r    [S+1];
  side_t       e_side_r [S+1];
  logic [15:0] a_in;
  logic [16:0] ae_in;

  always_comb begin
    a_in  = in_side.z[X_W-1] ? 16'(-in_side.z) : 16'(in_side.z);
    ae_in = (in_side.op == OP_TANH || in_side.op == OP_TANHD) ? {a_in, 1'b0} : {1'b0, a_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r[0] <= 1'b0;
    end else if (en) begin
      e_v_r[0] <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_val_r[0]  <= EXP_TAB[ae_in[7:0]];
      e_k_r[0]    <= ae_in[16:8];
      e_side_r[0] <= in_side;
    end
  end

  for (genvar i = 1; i <= S; i++) begin : g_exp
    logic [61:0] prod;
    logic [30:0] nxt;

    always_comb begin
      prod = 62'(e_val_r[i-1]) * 62'(E1);
      nxt  = (e_k_r[i-1] >= 9'(i)) ? prod[60:30] : e_val_r[i-1];
      if (i == S && e_k_r[i-1] > 9'(S)) nxt = '0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        e_v_r[i] <= 1'b0;
      end else if (en) begin
        e_v_r[i] <= e_v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_val_r[i]  <= nxt;
        e_k_r[i]    <= e_k_r[i-1];
        e_side_r[i] <= e_side_r[i-1];
      end
    end
  end

  // ---------------- divider ----------------
  logic [30:0] ev;
  logic [60:0] d_num;
  logic [31:0] d_den;
  side_t       es;
  logic        dv;
  logic [30:0] dq;
  side_t       dside;

  assign ev = e_val_r[S];
  assign es = e_side_r[S];

  always_comb begin
    d_num = {1'b1, 60'd0};
    d_den = 32'(Q30_ONE) + 32'(ev);
    unique case (es.op)
      OP_SIG, OP_SIGD: begin
        if (es.z[X_W-1]) d_num = {ev, 30'd0};
      end
      OP_TANH, OP_TANHD: begin
        d_num = {Q30_ONE - ev, 30'd0};
      end
      OP_SOFTP: begin
        d_num = {ev, 30'd0};
        d_den = 32'h8000_0000 + 32'(ev);
      end
      OP_ZERO: begin
      end
      default: begin
      end
    endcase
  end

  nau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (e_v_r[S]),
    .num      (d_num),
    .den      (d_den),
    .in_side  (es),
    .out_v    (dv),
    .quo      (dq),
    .out_side (dside)
  );

  // ---------------- product stage ----------------
  logic        pm_v_r;
  logic [30:0] pm_q_r, pm_m_r;
  side_t       pm_side_r;
  logic [30:0] msel;
  logic [61:0] mprod;

  assign msel  = (dside.op == OP_SIGD) ? Q30_ONE - dq : dq;
  assign mprod = 62'(dq) * 62'(msel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= 1'b0;
    end else if (en) begin
      pm_v_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_q_r    <= dq;
      pm_m_r    <= mprod[60:30];
      pm_side_r <= dside;
    end
  end

  // ---------------- log series ----------------
  // Each stage advances the odd power of w and starts the division of that
  // term by its odd divisor; the next stage corrects the quotient and sums.
  logic        l_v_r    [L];
  logic [30:0] l_p_r    [L];
  logic [30:0] l_pc_r   [L];
  logic [30:0] l_q0_r   [L];
  logic [31:0] l_sum_r  [L];
  logic [30:0] l_q_r    [L];
  logic [30:0] l_m_r    [L];
  side_t       l_side_r [L];

  for (genvar i = 0; i < L; i++) begin : g_ln
    localparam int PREVD = (i == 0) ? 1 : 2 * i - 1;
    logic        vin;
    logic [30:0] p_in, pc_in, q0_in, qv_in, mv_in;
    logic [31:0] sum_in;
    side_t       sd_in;
    logic [61:0] pp, pq;
    logic [30:0] rem, corr;

    if (i == 0) begin : g_first
      assign vin    = pm_v_r;
      assign p_in   = pm_q_r;
      assign pc_in  = '0;
      assign q0_in  = '0;
      assign sum_in = '0;
      assign qv_in  = pm_q_r;
      assign mv_in  = pm_m_r;
      assign sd_in  = pm_side_r;
    end else begin : g_next
      assign vin    = l_v_r[i-1];
      assign p_in   = l_p_r[i-1];
      assign pc_in  = l_pc_r[i-1];
      assign q0_in  = l_q0_r[i-1];
      assign sum_in = l_sum_r[i-1];
      assign qv_in  = l_q_r[i-1];
      assign mv_in  = l_m_r[i-1];
      assign sd_in  = l_side_r[i-1];
    end

    always_comb begin
      pp   = 62'(p_in) * 62'(mv_in);
      pq   = 62'(p_in) * 62'(RECIP[i]);
      rem  = pc_in - 31'(q0_in * 31'(PREVD));
      corr = q0_in + 31'(rem >= 31'(PREVD));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        l_v_r[i] <= 1'b0;
      end else if (en) begin
        l_v_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        l_p_r[i]    <= pp[60:30];
        l_pc_r[i]   <= p_in;
        l_q0_r[i]   <= pq[60:30];
        l_sum_r[i]  <= sum_in + 32'(corr);
        l_q_r[i]    <= qv_in;
        l_m_r[i]    <= mv_in;
        l_side_r[i] <= sd_in;
      end
    end
  end

  // last term correction
  localparam int LASTD = 2 * L - 1;
  logic        f_v_r;
  logic [31:0] f_sum_r;
  logic [30:0] f_q_r, f_m_r;
  side_t       f_side_r;
  logic [30:0] f_rem, f_corr;

  always_comb begin
    f_rem  = l_pc_r[L-1] - 31'(l_q0_r[L-1] * 31'(LASTD));
    f_corr = l_q0_r[L-1] + 31'(f_rem >= 31'(LASTD));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= l_v_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_sum_r  <= l_sum_r[L-1] + 32'(f_corr);
      f_q_r    <= l_q_r[L-1];
      f_m_r    <= l_m_r[L-1];
      f_side_r <= l_side_r[L-1];
    end
  end

  // ---------------- output ----------------
  logic [19:0] mag_q, mag_m, mag_td, mag_ln;
  logic [24:0] sp_sum;

  always_comb begin
    mag_q  = to_q16({2'b00, f_q_r});
    mag_m  = to_q16({2'b00, f_m_r});
    mag_td = to_q16({2'b00, Q30_ONE - f_m_r});
    mag_ln = to_q16({f_sum_r, 1'b0});
    sp_sum = 25'(mag_ln);
    if (!f_side_r.z[X_W-1] && f_side_r.z != '0) begin
      sp_sum = sp_sum + {1'b0, f_side_r.z, 8'd0};
    end
    y_nxt = '0;
    unique case (f_side_r.op)
      OP_SIG:   y_nxt = {{(Y_W-20){1'b0}}, mag_q};
      OP_SIGD:  y_nxt = {{(Y_W-20){1'b0}}, mag_m};
      OP_TANH: begin
        if (f_side_r.z[X_W-1]) y_nxt = Y_W'(0) - {{(Y_W-20){1'b0}}, mag_q};
        else                   y_nxt = {{(Y_W-20){1'b0}}, mag_q};
      end
      OP_TANHD: y_nxt = {{(Y_W-20){1'b0}}, mag_td};
      OP_SOFTP: begin
        if (sp_sum > 25'h7f_ffff) y_nxt = 24'h7f_ffff;
        else                      y_nxt = sp_sum[Y_W-1:0];
      end
      OP_ZERO:  y_nxt = '0;
      default:  y_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_y_r <= y_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_y = out_y_r;

  a_exp_gone: assert property (@(posedge clk) disable iff (!rst_n)
    (e_v_r[S] && e_k_r[S] >= 9'(EXP_ZERO_K)) |-> (e_val_r[S] == '0))
    else $error("e^-a chain not zero after many steps");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv |-> (dq <= Q30_ONE))
    else $error("quotient above one");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (en && f_v_r && f_side_r.op != OP_TANH) |=> !out_y_r[Y_W-1])
    else $error("negative result from a non-tanh function");

endmodule
`default_nettype wire

@@ rtl/neural_activation_unit_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// neural_activation_unit_top
// Q8.8 in, Q8.16 out activation unit: sigmoid, tanh, softplus and derivatives.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  ----------+-------------------+-------------------------------
//  input     | push / full       | in_func, in_x_value
//  result    | empty / pop       | out_y_value
//  config    | psel/penable/...  | input_gain at paddr 0
//
//  One item per cycle sustained while results are popped; an item passes through
//  the 24 e^-1 multiply stages, the 31-stage divider and the 16-term log series.
//  Reset (rst_n low, synchronous) empties every stage; gain returns to 1.0.
//  A stalled result freezes the whole function pipeline; the input queue keeps
//  taking items until it fills.
// ----------------------------------------------------------------------------
module neural_activation_unit_top import nau_pkg::*; #(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic signed [X_W-1:0] in_x_value,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [Y_W-1:0] out_y_value,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  logic signed [GAIN_W-1:0] gain_r;
  logic                     q_push, q_full, q_empty, q_pop, out_v;
  side_t                    f_side, q_side;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_GAIN_IDX) begin
      gain_r <= pwdata[GAIN_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_GAIN_IDX) ?
                  {{(PDATA_W-GAIN_W){gain_r[GAIN_W-1]}}, gain_r} : '0;

  nau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_func    (in_func),
    .in_x_value (in_x_value),
    .gain       (gain_r),
    .q_push     (q_push),
    .q_side     (f_side),
    .q_full     (q_full)
  );

  nau_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_side (f_side),
    .full      (q_full),
    .pop       (q_pop),
    .pop_side  (q_side),
    .empty     (q_empty)
  );

  nau_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (!q_empty),
    .in_side (q_side),
    .take    (q_pop),
    .out_v   (out_v),
    .out_pop (pop),
    .out_y   (out_y_value)
  );

  assign empty = !out_v;

endmodule
`default_nettype wire
